// ===== sv/dbpc_pkg.sv =====
package dbpc_pkg;

   localparam int BOX_VALUES = 4;
   localparam int POS_W      = 8;
   localparam int CLS_W      = 7;
   localparam int VAL_W      = 32;

   localparam logic KIND_FINISH = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_WIDTH     = 2'd1;
   localparam logic [1:0] CSR_HEIGHT    = 2'd2;
   localparam logic [1:0] CSR_CLASSES   = 2'd3;

   typedef struct packed {
      logic                   kind;
      logic [CLS_W-1:0]       cls;
      logic [VAL_W-1:0]       score;
      logic [3:0][VAL_W-1:0]  box;
   } job_type;

   typedef struct packed {
      logic                   found;
      logic [CLS_W-1:0]       class_index;
      logic [VAL_W-1:0]       confidence;
      logic [VAL_W-1:0]       box_left;
      logic [VAL_W-1:0]       box_top;
      logic [VAL_W-1:0]       box_width;
      logic [VAL_W-1:0]       box_height;
   } rsp_type;

endpackage

// ===== sv/dbpc_ram.sv =====
module dbpc_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 80
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/dbpc_queue.sv =====
module dbpc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dbpc_pkg::job_type push_data,
   input  logic              pop,
   output dbpc_pkg::job_type head,
   output logic              not_empty,
   output logic              full
);
   dbpc_pkg::job_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
endmodule

// ===== sv/dbpc_front.sv =====
module dbpc_front #(
   parameter int NUM_CLASSES = 80
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              action,
   input  logic [31:0]       element_value,
   input  logic [6:0]        class_select,
   input  logic [16:0]       score_threshold,
   input  logic [6:0]        classes_in_use,
   output logic              job_push,
   output dbpc_pkg::job_type job
);
   logic [dbpc_pkg::POS_W-1:0]   pos_ff;
   logic [3:0][31:0]             box_ff;
   logic [31:0]                  best_ff;
   logic [dbpc_pkg::CLS_W-1:0]   bcls_ff;

   logic [8:0]  n_clamp;
   logic [8:0]  last;
   logic        take;
   logic [31:0] best_in;
   logic [6:0]  bcls_in;
   logic [6:0]  cls_out;
   logic        row_end;
   logic        keep;

   always_comb begin
      n_clamp = {2'b00, classes_in_use};
      if (n_clamp == 9'd0) begin
         n_clamp = 9'd1;
      end
      if (n_clamp > 9'(NUM_CLASSES)) begin
         n_clamp = 9'(NUM_CLASSES);
      end
      last    = n_clamp + 9'd3;
      take    = (pos_ff == 8'd4) || ($signed(element_value) > $signed(best_ff));
      best_in = take ? element_value : best_ff;
      bcls_in = take ? 7'(pos_ff - 8'd4) : bcls_ff;
      cls_out = bcls_in;
      if ({2'b00, bcls_in} > 9'(NUM_CLASSES - 1)) begin
         cls_out = 7'(NUM_CLASSES - 1);
      end
      row_end = (pos_ff >= 8'd4) && ({1'b0, pos_ff} >= last);
      keep    = $signed({best_in[31], best_in}) >= $signed({16'd0, score_threshold});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         box_ff  <= '0;
         best_ff <= '0;
         bcls_ff <= '0;
      end else if (accept && action == dbpc_pkg::KIND_FINISH) begin
         if (pos_ff < 8'd4) begin
            box_ff[pos_ff[1:0]] <= element_value;
            pos_ff <= pos_ff + 8'd1;
         end else begin
            best_ff <= best_in;
            bcls_ff <= bcls_in;
            pos_ff  <= row_end ? 8'd0 : pos_ff + 8'd1;
         end
      end
   end

   always_comb begin
      job_push  = 1'b0;
      job.kind  = action;
      job.cls   = cls_out;
      job.score = best_in;
      job.box   = box_ff;
      if (accept) begin
         if (action == dbpc_pkg::KIND_READ) begin
            job_push = 1'b1;
            job.cls  = class_select;
         end else begin
            job_push = row_end && keep;
         end
      end
   end
endmodule

// ===== sv/dbpc_back.sv =====
module dbpc_back #(
   parameter int NUM_CLASSES = 80
) (
   input  logic              clock,
   input  logic              reset,
   input  dbpc_pkg::job_type job,
   input  logic              job_ready,
   output logic              job_pop,
   input  logic [15:0]       image_width,
   input  logic [15:0]       image_height,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output dbpc_pkg::rsp_type rsp
);
   localparam int IW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD, ST_RESP, ST_LOAD, ST_DIV, ST_SAT, ST_UPD
   } state_type;

   state_type          state_ff;
   dbpc_pkg::job_type  job_ff;
   logic [NUM_CLASSES-1:0] valid_ff;
   logic [33:0]        num_ff;
   logic [16:0]        rem_ff;
   logic [16:0]        den_ff;
   logic               neg_ff;
   logic [5:0]         bit_ff;
   logic [1:0]         k_ff;
   logic [3:0][31:0]   res_ff;
   logic               out_valid_ff;
   dbpc_pkg::rsp_type  out_ff;

   logic [IW-1:0]      idx;
   logic               in_range;
   logic [159:0]       rd_data;
   logic               wr_en;
   logic [16:0]        wd;
   logic [16:0]        ht;
   logic signed [33:0] num_in;
   logic [16:0]        den_in;
   logic [17:0]        rem_sh;
   logic               ge;
   logic [31:0]        sat;

   assign idx      = IW'(job_ff.cls);
   assign in_range = {2'b00, job_ff.cls} < 9'(NUM_CLASSES);
   assign wr_en    = (state_ff == ST_UPD)
                     && (!valid_ff[idx] || $signed(rd_data[159:128]) < $signed(job_ff.score));

   dbpc_ram #(.WIDTH(160), .DEPTH(NUM_CLASSES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx),
      .wr_data ({job_ff.score, res_ff[0], res_ff[1], res_ff[2], res_ff[3]}),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

   always_comb begin
      wd = (image_width == 16'd0) ? 17'd1 : {1'b0, image_width};
      ht = (image_height == 16'd0) ? 17'd1 : {1'b0, image_height};
      case (k_ff)
         2'd0: begin
            num_in = {{2{job_ff.box[0][31]}}, job_ff.box[0]} * 34'sd2
                     - {{2{job_ff.box[2][31]}}, job_ff.box[2]};
            den_in = {wd[15:0], 1'b0};
         end
         2'd1: begin
            num_in = {{2{job_ff.box[1][31]}}, job_ff.box[1]} * 34'sd2
                     - {{2{job_ff.box[3][31]}}, job_ff.box[3]};
            den_in = {ht[15:0], 1'b0};
         end
         2'd2: begin
            num_in = {{2{job_ff.box[2][31]}}, job_ff.box[2]};
            den_in = wd;
         end
         default: begin
            num_in = {{2{job_ff.box[3][31]}}, job_ff.box[3]};
            den_in = ht;
         end
      endcase
      rem_sh = {rem_ff, num_ff[33]};
      ge     = rem_sh >= {1'b0, den_ff};
      // truncated quotient magnitude, then clip to the signed 32-bit range
      if (!neg_ff) begin
         sat = (num_ff > 34'h07FFF_FFFF) ? 32'h7FFF_FFFF : num_ff[31:0];
      end else begin
         sat = (num_ff > 34'h080000000) ? 32'h8000_0000 : 32'(-num_ff);
      end
   end

   assign job_pop   = (state_ff == ST_IDLE) && job_ready;
   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (job_ready) begin
                  job_ff   <= job;
                  k_ff     <= 2'd0;
                  state_ff <= (job.kind == dbpc_pkg::KIND_READ) ? ST_RD : ST_LOAD;
               end
            end
            ST_RD: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (!out_valid_ff) begin
                  out_valid_ff          <= 1'b1;
                  out_ff.class_index    <= job_ff.cls;
                  if (in_range && valid_ff[idx]) begin
                     valid_ff[idx]      <= 1'b0;
                     out_ff.found       <= 1'b1;
                     out_ff.confidence  <= rd_data[159:128];
                     out_ff.box_left    <= rd_data[127:96];
                     out_ff.box_top     <= rd_data[95:64];
                     out_ff.box_width   <= rd_data[63:32];
                     out_ff.box_height  <= rd_data[31:0];
                  end else begin
                     out_ff.found       <= 1'b0;
                     out_ff.confidence  <= '0;
                     out_ff.box_left    <= '0;
                     out_ff.box_top     <= '0;
                     out_ff.box_width   <= '0;
                     out_ff.box_height  <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_LOAD: begin
               neg_ff   <= num_in[33];
               num_ff   <= num_in[33] ? 34'(-num_in) : 34'(num_in);
               den_ff   <= den_in;
               rem_ff   <= '0;
               bit_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff <= ge ? 17'(rem_sh - {1'b0, den_ff}) : rem_sh[16:0];
               num_ff <= {num_ff[32:0], ge};
               bit_ff <= bit_ff + 6'd1;
               if (bit_ff == 6'd33) begin
                  state_ff <= ST_SAT;
               end
            end
            ST_SAT: begin
               res_ff[k_ff] <= sat;
               k_ff         <= k_ff + 2'd1;
               state_ff     <= (k_ff == 2'd3) ? ST_UPD : ST_LOAD;
            end
            ST_UPD: begin
               if (wr_en) begin
                  valid_ff[idx] <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule

// ===== sv/detection_decode_best_per_class.sv =====
// a read beat passes the job queue, ST_IDLE, ST_RD and ST_RESP; a full result slot holds it
// the element closing a kept row costs four ST_LOAD/ST_DIV/ST_SAT passes, then ST_UPD
// throughput: one beat a cycle while the two-entry job queue has room; the serial divider
// (one quotient bit a cycle, four quotients per kept row) sets the sustained rate
// reset: synchronous, active high; clears row state, valid bits, job queue, result slot
module detection_decode_best_per_class #(
   parameter int NUM_CLASSES = 80
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_action,
   input  logic [31:0] req_element_value,
   input  logic [6:0]  req_class_select,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_found,
   output logic [6:0]  rsp_class_index,
   output logic [31:0] rsp_confidence,
   output logic [31:0] rsp_box_left,
   output logic [31:0] rsp_box_top,
   output logic [31:0] rsp_box_width,
   output logic [31:0] rsp_box_height,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   logic [16:0] threshold_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic [6:0]  classes_ff;

   logic              accept;
   logic              job_push;
   dbpc_pkg::job_type job_in;
   dbpc_pkg::job_type job_head;
   logic              job_ready;
   logic              job_pop;
   dbpc_pkg::rsp_type rsp;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 17'd16384;
         width_ff     <= 16'd640;
         height_ff    <= 16'd640;
         classes_ff   <= 7'd80;
      end else if (csr_valid) begin
         case (csr_index)
            dbpc_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
            dbpc_pkg::CSR_WIDTH:     width_ff     <= csr_wdata[15:0];
            dbpc_pkg::CSR_HEIGHT:    height_ff    <= csr_wdata[15:0];
            dbpc_pkg::CSR_CLASSES:   classes_ff   <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   dbpc_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .action          (req_action),
      .element_value   (req_element_value),
      .class_select    (req_class_select),
      .score_threshold (threshold_ff),
      .classes_in_use  (classes_ff),
      .job_push        (job_push),
      .job             (job_in)
   );

   dbpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .head      (job_head),
      .not_empty (job_ready),
      .full      (req_full)
   );

   dbpc_back #(.NUM_CLASSES(NUM_CLASSES)) u_back (
      .clock        (clock),
      .reset        (reset),
      .job          (job_head),
      .job_ready    (job_ready),
      .job_pop      (job_pop),
      .image_width  (width_ff),
      .image_height (height_ff),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp          (rsp)
   );

   assign rsp_found       = rsp.found;
   assign rsp_class_index = rsp.class_index;
   assign rsp_confidence  = rsp.confidence;
   assign rsp_box_left    = rsp.box_left;
   assign rsp_box_top     = rsp.box_top;
   assign rsp_box_width   = rsp.box_width;
   assign rsp_box_height  = rsp.box_height;
endmodule

// ===== sv/dbpc_checker.sv =====
module dbpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_found,
   input logic [31:0] rsp_confidence,
   input logic [31:0] rsp_box_left,
   input logic [31:0] rsp_box_height
);
   // nothing waits on the result side straight after reset
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   // an empty class reads back as zeros
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_found) |-> (rsp_confidence == 32'd0 && rsp_box_left == 32'd0
                                      && rsp_box_height == 32'd0))
      else $error("empty entry carries data");

   // a beat that is not taken stays put
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_confidence)))
      else $error("result changed while stalled");

   // the job queue comes out of reset with room
   assert property (@(posedge clock) reset |=> !req_full)
      else $error("input side full after reset");
endmodule

bind detection_decode_best_per_class dbpc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_found      (rsp_found),
   .rsp_confidence (rsp_confidence),
   .rsp_box_left   (rsp_box_left),
   .rsp_box_height (rsp_box_height)
);
